@@ rtl/lfpd_pkg.sv @@
package lfpd_pkg;

	localparam int unsigned SENSOR_W = 8;
	localparam int unsigned ERR_W    = 4;
	localparam int unsigned CORR_W   = 8;
	localparam int unsigned SPEED_W  = 7;
	localparam int unsigned GAIN_W   = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 7;
	// Wide enough for the unclamped PD sum and for base plus or minus correction.
	localparam int unsigned CALC_W   = 10;

	localparam logic [SPEED_W-1:0] CRUISE_RST      = 7'd20;
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 4'd4;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 4'd1;
	localparam logic [SPEED_W-1:0] DRIVE_LIMIT_RST = 7'd25;
	localparam logic [SPEED_W-1:0] SPD_FLOOR_RST   = 7'd5;
	localparam logic [SPEED_W-1:0] SPD_CEIL_RST    = 7'd40;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CRUISE      = 3'd0,
		CFG_PROP_GAIN   = 3'd1,
		CFG_DERIV_GAIN  = 3'd2,
		CFG_DRIVE_LIMIT = 3'd3,
		CFG_SPD_FLOOR   = 3'd4,
		CFG_SPD_CEIL    = 3'd5
	} lfpd_cfg_idx_t;

	typedef struct packed {
		logic [SPEED_W-1:0] cruise_spd;
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [SPEED_W-1:0] drive_limit;
		logic [SPEED_W-1:0] spd_floor;
		logic [SPEED_W-1:0] spd_ceil;
	} lfpd_cfg_t;

	// Current error and the error of the previous word.
	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic signed [ERR_W-1:0] last;
	} lfpd_err_t;

	typedef struct packed {
		logic                    hit;
		logic signed [ERR_W-1:0] err;
	} lfpd_lut_t;

	function automatic lfpd_lut_t lfpd_pattern_err(input logic [SENSOR_W-1:0] bits);
		lfpd_lut_t r;
		r.hit = 1'b1;
		r.err = 4'sd0;
		case (bits)
			8'd0:   r.err = 4'sd0;
			8'd16:  r.err = 4'sd1;
			8'd8:   r.err = 4'sd1;
			8'd24:  r.err = 4'sd0;
			8'd60:  r.err = 4'sd0;
			8'd126: r.err = 4'sd0;
			8'd48:  r.err = 4'sd2;
			8'd32:  r.err = 4'sd2;
			8'd64:  r.err = 4'sd4;
			8'd96:  r.err = 4'sd4;
			8'd128: r.err = 4'sd6;
			8'd192: r.err = 4'sd6;
			8'd224: r.err = 4'sd6;
			8'd160: r.err = 4'sd6;
			8'd254: r.err = 4'sd6;
			8'd252: r.err = 4'sd6;
			8'd248: r.err = 4'sd6;
			8'd240: r.err = 4'sd6;
			8'd124: r.err = 4'sd4;
			8'd120: r.err = 4'sd4;
			8'd56:  r.err = 4'sd2;
			8'd12:  r.err = -4'sd2;
			8'd14:  r.err = -4'sd4;
			8'd30:  r.err = -4'sd4;
			8'd62:  r.err = -4'sd4;
			8'd31:  r.err = -4'sd6;
			8'd63:  r.err = -4'sd6;
			8'd125: r.err = -4'sd6;
			8'd4:   r.err = -4'sd2;
			8'd28:  r.err = -4'sd2;
			8'd2:   r.err = -4'sd4;
			8'd6:   r.err = -4'sd4;
			8'd1:   r.err = -4'sd6;
			8'd3:   r.err = -4'sd6;
			8'd7:   r.err = -4'sd6;
			8'd15:  r.err = -4'sd6;
			default: begin
				r.hit = 1'b0;
				r.err = 4'sd0;
			end
		endcase
		return r;
	endfunction

	// Raise to lo first, then lower to hi, so hi wins when lo is above hi.
	function automatic logic [SPEED_W-1:0] lfpd_clamp_speed(
		input logic signed [CALC_W-1:0] v,
		input logic [SPEED_W-1:0]       lo,
		input logic [SPEED_W-1:0]       hi
	);
		logic signed [CALC_W-1:0] t;
		logic signed [CALC_W-1:0] lo_w;
		logic signed [CALC_W-1:0] hi_w;
		lo_w = $signed({{(CALC_W-SPEED_W){1'b0}}, lo});
		hi_w = $signed({{(CALC_W-SPEED_W){1'b0}}, hi});
		t = v;
		if (t < lo_w) t = lo_w;
		if (t > hi_w) t = hi_w;
		return t[SPEED_W-1:0];
	endfunction

endpackage

@@ rtl/lfpd_err_track.sv @@
module lfpd_err_track (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lfpd_pkg::SENSOR_W-1:0]    sensor_bits,
	input  logic                             update,
	output lfpd_pkg::lfpd_err_t              errs
);
	import lfpd_pkg::*;

	logic signed [ERR_W-1:0] last_error_q;
	lfpd_lut_t               lut;

	assign lut = lfpd_pattern_err(sensor_bits);

	// An unknown pattern keeps the previous error.
	assign errs.err  = lut.hit ? lut.err : last_error_q;
	assign errs.last = last_error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
		end else if (update) begin
			last_error_q <= errs.err;
		end
	end

	a_last_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(last_error_q >= -4'sd6) && (last_error_q <= 4'sd6))
		else $error("held error left the table range");

	a_hold_without_update: assert property (@(posedge clk) disable iff (!arst_n)
		!update |=> $stable(last_error_q))
		else $error("held error changed without a word moving");

	a_known_pattern_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(update && lut.hit) |=> (last_error_q == $past(lut.err)))
		else $error("known pattern error was not stored");

endmodule

@@ rtl/lfpd_pd_calc.sv @@
module lfpd_pd_calc (
	input  lfpd_pkg::lfpd_cfg_t                    cfg,
	input  lfpd_pkg::lfpd_err_t                    errs,
	output logic signed [lfpd_pkg::CORR_W-1:0]     correction,
	output logic [lfpd_pkg::SPEED_W-1:0]           wheel_left,
	output logic [lfpd_pkg::SPEED_W-1:0]           wheel_right
);
	import lfpd_pkg::*;

	logic signed [CALC_W-1:0] err_w;
	logic signed [CALC_W-1:0] last_w;
	logic signed [CALC_W-1:0] kp_w;
	logic signed [CALC_W-1:0] kd_w;
	logic signed [CALC_W-1:0] lim_w;
	logic signed [CALC_W-1:0] base_w;
	logic signed [CALC_W-1:0] diff_w;
	logic signed [CALC_W-1:0] p_term;
	logic signed [CALC_W-1:0] d_term;
	logic signed [CALC_W-1:0] pd_sum;
	logic signed [CALC_W-1:0] pd_clamped;

	assign err_w  = {{(CALC_W-ERR_W){errs.err[ERR_W-1]}}, errs.err};
	assign last_w = {{(CALC_W-ERR_W){errs.last[ERR_W-1]}}, errs.last};
	assign kp_w   = {{(CALC_W-GAIN_W){1'b0}}, cfg.prop_gain};
	assign kd_w   = {{(CALC_W-GAIN_W){1'b0}}, cfg.deriv_gain};
	assign lim_w  = {{(CALC_W-SPEED_W){1'b0}}, cfg.drive_limit};
	assign base_w = {{(CALC_W-SPEED_W){1'b0}}, cfg.cruise_spd};

	assign diff_w = err_w - last_w;
	assign p_term = kp_w * err_w;
	assign d_term = kd_w * diff_w;
	assign pd_sum = p_term + d_term;

	always_comb begin
		pd_clamped = pd_sum;
		if (pd_clamped > lim_w) pd_clamped = lim_w;
		if (pd_clamped < -lim_w) pd_clamped = -lim_w;
	end

	assign correction  = pd_clamped[CORR_W-1:0];
	assign wheel_left  = lfpd_clamp_speed(base_w - pd_clamped, cfg.spd_floor, cfg.spd_ceil);
	assign wheel_right = lfpd_clamp_speed(base_w + pd_clamped, cfg.spd_floor, cfg.spd_ceil);

endmodule

@@ rtl/line_follow_pd_drive_core.sv @@
// PD steering for a line-following car.
// Input channel: one 8-bit sensor word (sensor_bits) per handshake on
// in_valid / in_stall. Output channel: line_error, correction, wheel_left and
// wheel_right on out_valid / out_stall. A word moves when valid is high and
// stall is low.
// One input register, then the table lookup and PD arithmetic feed the output
// register, and out_valid rises as a word moves into it. Throughput is one word
// per cycle while the receiver does not stall; the held error register is
// updated as each word moves into the output register, so consecutive words
// see the right previous error.
// When the receiver stalls, the output word holds and the input register still
// fills once; after that in_stall rises until the output frees up.
// Configuration registers are written through cfg_valid / cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, unknown indexes are ignored,
// and writes are meant to happen while no word is in flight.
// Reset clears the pipeline, sets the held error to zero and loads the
// default gains, limits and speeds.
module line_follow_pd_drive_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [lfpd_pkg::SENSOR_W-1:0]           sensor_bits,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [lfpd_pkg::ERR_W-1:0]       line_error,
	output logic signed [lfpd_pkg::CORR_W-1:0]      correction,
	output logic [lfpd_pkg::SPEED_W-1:0]            wheel_left,
	output logic [lfpd_pkg::SPEED_W-1:0]            wheel_right,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [lfpd_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import lfpd_pkg::*;

	lfpd_cfg_t               cfg_q;
	logic                    valid_s1;
	logic [SENSOR_W-1:0]     sensor_s1;
	logic                    advance;
	logic                    in_take;
	lfpd_err_t               errs;
	logic signed [CORR_W-1:0] corr_c;
	logic [SPEED_W-1:0]      left_c;
	logic [SPEED_W-1:0]      right_c;
	logic                    out_valid_q;
	logic signed [ERR_W-1:0] line_error_q;
	logic signed [CORR_W-1:0] correction_q;
	logic [SPEED_W-1:0]      wheel_left_q;
	logic [SPEED_W-1:0]      wheel_right_q;
	logic signed [CALC_W-1:0] corr_chk;
	logic signed [CALC_W-1:0] lim_chk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cruise_spd  <= CRUISE_RST;
			cfg_q.prop_gain   <= PROP_GAIN_RST;
			cfg_q.deriv_gain  <= DERIV_GAIN_RST;
			cfg_q.drive_limit <= DRIVE_LIMIT_RST;
			cfg_q.spd_floor   <= SPD_FLOOR_RST;
			cfg_q.spd_ceil    <= SPD_CEIL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CRUISE:      cfg_q.cruise_spd  <= cfg_data[SPEED_W-1:0];
				CFG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data[GAIN_W-1:0];
				CFG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data[GAIN_W-1:0];
				CFG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg_data[SPEED_W-1:0];
				CFG_SPD_FLOOR:   cfg_q.spd_floor   <= cfg_data[SPEED_W-1:0];
				CFG_SPD_CEIL:    cfg_q.spd_ceil    <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// The word in the input register moves on whenever the output register is
	// empty or being taken this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sensor_s1 <= sensor_bits;
		end
	end

	lfpd_err_track u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.sensor_bits (sensor_s1),
		.update      (advance),
		.errs        (errs)
	);

	lfpd_pd_calc u_calc (
		.cfg         (cfg_q),
		.errs        (errs),
		.correction  (corr_c),
		.wheel_left  (left_c),
		.wheel_right (right_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_error_q  <= errs.err;
			correction_q  <= corr_c;
			wheel_left_q  <= left_c;
			wheel_right_q <= right_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_error  = line_error_q;
	assign correction  = correction_q;
	assign wheel_left  = wheel_left_q;
	assign wheel_right = wheel_right_q;

	assign corr_chk = {{(CALC_W-CORR_W){correction_q[CORR_W-1]}}, correction_q};
	assign lim_chk  = {{(CALC_W-SPEED_W){1'b0}}, cfg_q.drive_limit};

	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted word did not reach the input register");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked output");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(sensor_s1)))
		else $error("blocked input word was lost or changed");

	a_corr_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((corr_chk <= lim_chk) && (corr_chk >= -lim_chk)))
		else $error("correction outside the drive limit");

endmodule

@@ tb/sv/tb_line_follow_pd_drive_core.sv @@
module tb_line_follow_pd_drive_core;
	import lfpd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 6;
	localparam int N_PATTERNS   = 36;
	localparam int RANDOM_SETS  = 10;
	localparam int SET_WORDS    = 110;

	// Indexes past the register list; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// Each entry is {pattern, signed offset}.
	localparam logic [12*N_PATTERNS-1:0] LINE_TABLE = {
		8'd0, 4'sd0, 8'd16, 4'sd1, 8'd8, 4'sd1, 8'd24, 4'sd0,
		8'd60, 4'sd0, 8'd126, 4'sd0, 8'd48, 4'sd2, 8'd32, 4'sd2,
		8'd64, 4'sd4, 8'd96, 4'sd4, 8'd128, 4'sd6, 8'd192, 4'sd6,
		8'd224, 4'sd6, 8'd160, 4'sd6, 8'd254, 4'sd6, 8'd252, 4'sd6,
		8'd248, 4'sd6, 8'd240, 4'sd6, 8'd124, 4'sd4, 8'd120, 4'sd4,
		8'd56, 4'sd2, 8'd12, -4'sd2, 8'd14, -4'sd4, 8'd30, -4'sd4,
		8'd62, -4'sd4, 8'd31, -4'sd6, 8'd63, -4'sd6, 8'd125, -4'sd6,
		8'd4, -4'sd2, 8'd28, -4'sd2, 8'd2, -4'sd4, 8'd6, -4'sd4,
		8'd1, -4'sd6, 8'd3, -4'sd6, 8'd7, -4'sd6, 8'd15, -4'sd6
	};

	typedef struct packed {
		logic signed [ERR_W-1:0]  err;
		logic signed [CORR_W-1:0] corr;
		logic [SPEED_W-1:0]       left_spd;
		logic [SPEED_W-1:0]       right_spd;
	} drive_word_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SENSOR_W-1:0] sensor_bits = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ERR_W-1:0] line_error;
	logic signed [CORR_W-1:0] correction;
	logic [SPEED_W-1:0] wheel_left;
	logic [SPEED_W-1:0] wheel_right;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register copies and the held error, as the block should see them.
	int set_base = int'(CRUISE_RST);
	int set_prop = int'(PROP_GAIN_RST);
	int set_deriv = int'(DERIV_GAIN_RST);
	int set_limit = int'(DRIVE_LIMIT_RST);
	int set_min = int'(SPD_FLOOR_RST);
	int set_max = int'(SPD_CEIL_RST);
	int held_err = 0;

	logic [SENSOR_W-1:0] sensor_backlog [$];
	drive_word_t drive_words_due [$];

	int mismatches = 0;
	int words_taken = 0;
	int results_seen = 0;
	int settings_run = 0;
	int cycles = 0;
	int gap_max = 4;
	int burst_left = 0;
	int gap_left = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	line_follow_pd_drive_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sensor_bits (sensor_bits),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.line_error  (line_error),
		.correction  (correction),
		.wheel_left  (wheel_left),
		.wheel_right (wheel_right),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int clamp_wheel(input int v);
		int r;
		r = v;
		if (r < set_min) r = set_min;
		if (r > set_max) r = set_max;
		return r;
	endfunction

	function automatic drive_word_t steer_predict(input logic [SENSOR_W-1:0] bits);
		drive_word_t w;
		logic [11:0] e;
		int err;
		int pd;
		err = held_err;
		for (int k = 0; k < N_PATTERNS; k++) begin
			e = LINE_TABLE[k*12 +: 12];
			if (e[11:4] == bits) err = int'($signed(e[3:0]));
		end
		pd = set_prop * err + set_deriv * (err - held_err);
		if (pd > set_limit) pd = set_limit;
		if (pd < -set_limit) pd = -set_limit;
		w.err = ERR_W'(err);
		w.corr = CORR_W'(pd);
		w.left_spd = SPEED_W'(clamp_wheel(set_base - pd));
		w.right_spd = SPEED_W'(clamp_wheel(set_base + pd));
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch in %s at result %0d: got %0d, expected %0d",
				what, results_seen, got, want);
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		drive_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sensor_bits <= '0;
			held_err = 0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				w = steer_predict(sensor_bits);
				drive_words_due.push_back(w);
				held_err = int'(w.err);
				words_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (sensor_backlog.size() != 0) begin
					in_valid <= 1'b1;
					sensor_bits <= sensor_backlog.pop_front();
					if (burst_left > 0) burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						if (gap_max == 0 || $urandom_range(0, 3) == 0)
							gap_left = 0;
						else
							gap_left = $urandom_range(1, gap_max);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern; a requested hold-off overrides it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
			mode_left = 0;
		end else begin
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(8, 60);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		drive_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_words_due.size() == 0) begin
				report_mismatch("unexpected word", int'(line_error), 0);
			end else begin
				want = drive_words_due.pop_front();
				if (line_error !== want.err)
					report_mismatch("line_error", int'(line_error), int'(want.err));
				if (correction !== want.corr)
					report_mismatch("correction", int'(correction), int'(want.corr));
				if (wheel_left !== want.left_spd)
					report_mismatch("wheel_left", int'(wheel_left), int'(want.left_spd));
				if (wheel_right !== want.right_spd)
					report_mismatch("wheel_right", int'(wheel_right),
						int'(want.right_spd));
			end
			results_seen++;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CRUISE: set_base = int'(val);
			CFG_PROP_GAIN: set_prop = int'(val[GAIN_W-1:0]);
			CFG_DERIV_GAIN: set_deriv = int'(val[GAIN_W-1:0]);
			CFG_DRIVE_LIMIT: set_limit = int'(val);
			CFG_SPD_FLOOR: set_min = int'(val);
			CFG_SPD_CEIL: set_max = int'(val);
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] kp,
			input logic [CFG_DATA_W-1:0] kd, input logic [CFG_DATA_W-1:0] lim,
			input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
		write_reg(CFG_CRUISE, base);
		write_reg(CFG_PROP_GAIN, kp);
		write_reg(CFG_DERIV_GAIN, kd);
		write_reg(CFG_DRIVE_LIMIT, lim);
		write_reg(CFG_SPD_FLOOR, lo);
		write_reg(CFG_SPD_CEIL, hi);
		settings_run++;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_speed();
		logic [CFG_DATA_W-1:0] v;
		if ($urandom_range(0, 3) == 0)
			v = CFG_DATA_W'($urandom_range(0, 127));
		else
			v = CFG_DATA_W'($urandom_range(0, 100));
		return v;
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (sensor_backlog.size() != 0 || in_valid || drive_words_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [11:0] e;
		logic [SENSOR_W-1:0] b;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: table edges, full-on and full-off patterns, unknown patterns.
		settings_run++;
		sensor_backlog.push_back(8'd0);
		sensor_backlog.push_back(8'd255);
		sensor_backlog.push_back(8'd1);
		sensor_backlog.push_back(8'd128);
		sensor_backlog.push_back(8'd127);
		sensor_backlog.push_back(8'd15);
		sensor_backlog.push_back(8'd240);
		sensor_backlog.push_back(8'd31);
		sensor_backlog.push_back(8'd248);
		sensor_backlog.push_back(8'd129);
		sensor_backlog.push_back(8'd16);
		wait_drained();

		// Gains at maximum with full swings, so the PD sum goes far past the clamp.
		write_all(7'd127, 7'h7F, 7'h7F, 7'd127, 7'd0, 7'd127);
		sensor_backlog.push_back(8'd1);
		sensor_backlog.push_back(8'd128);
		sensor_backlog.push_back(8'd1);
		sensor_backlog.push_back(8'd0);
		sensor_backlog.push_back(8'd128);
		wait_drained();

		write_all(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
		sensor_backlog.push_back(8'd128);
		sensor_backlog.push_back(8'd1);
		wait_drained();

		// Minimum above maximum: both wheels must sit at the maximum.
		write_all(7'd60, 7'd9, 7'd3, 7'd50, 7'd100, 7'd20);
		sensor_backlog.push_back(8'd1);
		sensor_backlog.push_back(8'd128);
		wait_drained();

		write_reg(CFG_SPARE_LO, 7'h7F);
		write_reg(CFG_SPARE_HI, 7'h00);
		sensor_backlog.push_back(8'd64);
		sensor_backlog.push_back(8'd2);
		wait_drained();

		for (int s = 0; s < RANDOM_SETS; s++) begin
			write_all(pick_speed(), CFG_DATA_W'($urandom_range(0, 127)),
				CFG_DATA_W'($urandom_range(0, 127)), CFG_DATA_W'($urandom_range(0, 127)),
				pick_speed(), pick_speed());
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
					CFG_DATA_W'($urandom_range(0, 127)));
			gap_max = $urandom_range(0, 12);
			if (s == 2) begin
				// Long output hold-off with the sender never pausing.
				gap_max = 0;
				hold_asked++;
			end
			// Mostly patterns the table knows, with raw bytes mixed in.
			for (int n = 0; n < SET_WORDS; n++) begin
				if ($urandom_range(0, 4) != 0) begin
					e = LINE_TABLE[$urandom_range(0, N_PATTERNS - 1)*12 +: 12];
					b = e[11:4];
				end else begin
					b = SENSOR_W'($urandom_range(0, 255));
				end
				sensor_backlog.push_back(b);
			end
			wait_drained();
		end

		if (drive_words_due.size() != 0)
			report_mismatch("words never delivered", drive_words_due.size(), 0);
		$display("covered %0d sensor words and %0d results under %0d register settings",
			words_taken, results_seen, settings_run);
		$display("extreme gains and clamps, min above max, spare indexes, %0d-cycle hold-off",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lfpd_pkg.sv
rtl/lfpd_err_track.sv
rtl/lfpd_pd_calc.sv
rtl/line_follow_pd_drive_core.sv
tb/sv/tb_line_follow_pd_drive_core.sv
